FILE: hw/rtl/digitizer_word_pair_parser_top_macros.svh
// Assertion macros shared by the RTL files that check their own logic.
// Each macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef DIGITIZER_WORD_PAIR_PARSER_TOP_MACROS_SVH
`define DIGITIZER_WORD_PAIR_PARSER_TOP_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define DWPP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent holds in the cycle after the antecedent.
`define DWPP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hw/rtl/dwpp_pkg.sv
package dwpp_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam int ADDR_W     = 12;
    localparam int VALUE_W    = 16;
    localparam int TIME_W     = 64;
    localparam int TS_LOW_W   = 28;
    localparam int TS_HIGH_W  = TIME_W - TS_LOW_W;
    localparam int INFO_W     = 20;
    localparam int ADDR_STEP  = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TAPE_ENABLE  = 2'd0,
        CFG_TAPE_ADDR    = 2'd1,
        CFG_TAPE_PATTERN = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        WT_SKIP_A = 2'd0,
        WT_SKIP_B = 2'd1,
        WT_TIME   = 2'd2,
        WT_DATA   = 2'd3
    } t_word_type;

    typedef enum logic [2:0] {
        KIND_GOOD      = 3'd0,
        KIND_BAD_EOB   = 3'd1,
        KIND_BAD_ADDR  = 3'd2,
        KIND_BAD_TS    = 3'd3,
        KIND_PATTERN   = 3'd4
    } t_kind;

    localparam logic [3:0] INFO_TS_LOAD_A     = 4'd2;
    localparam logic [3:0] INFO_TS_LOAD_B     = 4'd3;
    localparam logic [3:0] INFO_TS_LOAD_C     = 4'd4;
    localparam logic [3:0] INFO_TS_LOAD_SHIFT = 4'd5;
    localparam logic [3:0] INFO_TS_LOAD_D     = 4'd7;

    localparam logic [1:0] PAT_JUNK = 2'd2;

    typedef struct packed {
        t_kind                kind;
        logic [ADDR_W-1:0]    chan_address;
        logic [TIME_W-1:0]    time_stamp;
        logic [VALUE_W-1:0]   charge_value;
        logic [VALUE_W-1:0]   cfd_value;
        logic [1:0]           pattern_code;
        logic [VALUE_W-1:0]   packet_id;
        logic                 last_result;
    } t_result;

    typedef struct packed {
        logic    two;
        t_result r0;
        t_result r1;
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_slot;

endpackage

FILE: hw/rtl/dwpp_stream_if.sv
interface dwpp_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] word;
    logic        last_in_buffer;

    modport source(output valid, output word, output last_in_buffer, input ready);
    modport sink(input valid, input word, input last_in_buffer, output ready);
endinterface

interface dwpp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [11:0] chan_address;
    logic [63:0] time_stamp;
    logic [15:0] charge_value;
    logic [15:0] cfd_value;
    logic [1:0]  pattern_code;
    logic [15:0] packet_id;
    logic        last_result;

    modport source(output valid, output kind, output chan_address, output time_stamp,
                   output charge_value, output cfd_value, output pattern_code,
                   output packet_id, output last_result, input ready);
    modport sink(input valid, input kind, input chan_address, input time_stamp,
                 input charge_value, input cfd_value, input pattern_code,
                 input packet_id, input last_result, output ready);
endinterface

FILE: hw/rtl/dwpp_front.sv
module dwpp_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    dwpp_in_if.sink                             i_in,
    input  logic                                i_cfg_we,
    input  logic [dwpp_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [dwpp_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_q_full,
    output dwpp_pkg::t_slot                     o_push
);

    logic                                r_tape_enable;
    logic [dwpp_pkg::ADDR_W-1:0]         r_tape_addr;
    logic [1:0]                          r_tape_pattern;

    logic [dwpp_pkg::TS_HIGH_W-1:0]      r_ts_high;
    logic [dwpp_pkg::TS_HIGH_W-1:0]      n_ts_high;
    logic                                r_pend_valid;
    logic                                n_pend_valid;
    logic [dwpp_pkg::ADDR_W-1:0]         r_pend_addr;
    logic [dwpp_pkg::ADDR_W-1:0]         n_pend_addr;
    logic [dwpp_pkg::TIME_W-1:0]         r_pend_time;
    logic [dwpp_pkg::TIME_W-1:0]         n_pend_time;
    logic [dwpp_pkg::VALUE_W-1:0]        r_pend_charge;
    logic [dwpp_pkg::VALUE_W-1:0]        n_pend_charge;

    logic                                accept;
    logic [63:0]                         w;
    dwpp_pkg::t_word_type                w_type;
    logic [3:0]                          w_info;
    logic [dwpp_pkg::ADDR_W-1:0]         w_addr;
    logic [dwpp_pkg::VALUE_W-1:0]        w_val;
    logic [dwpp_pkg::TIME_W-1:0]         w_time;
    logic [dwpp_pkg::ADDR_W:0]           addr_next;
    logic                                pair_good;
    logic                                fresh_en;
    logic                                fres_valid;
    dwpp_pkg::t_result                   pair;
    dwpp_pkg::t_result                   fres;

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && !i_q_full;

    assign w         = i_in.word;
    assign w_type    = dwpp_pkg::t_word_type'(w[63:62]);
    assign w_info    = w[55:52];
    assign w_addr    = w[59:48];
    assign w_val     = w[47:32];
    assign w_time    = {r_ts_high, w[dwpp_pkg::TS_LOW_W-1:0]};
    assign addr_next = {1'b0, r_pend_addr} + (dwpp_pkg::ADDR_W+1)'(dwpp_pkg::ADDR_STEP);

    always_comb begin
        pair              = '0;
        pair.chan_address = r_pend_addr;
        pair.time_stamp   = r_pend_time;
        pair.charge_value = r_pend_charge;
        pair_good         = 1'b0;
        if ({1'b0, w_addr} != addr_next) begin
            pair.kind = dwpp_pkg::KIND_BAD_ADDR;
        end else if (w_time != r_pend_time) begin
            pair.kind = dwpp_pkg::KIND_BAD_TS;
        end else begin
            pair.kind      = dwpp_pkg::KIND_GOOD;
            pair.cfd_value = w_val;
            pair_good      = 1'b1;
        end
    end

    assign fresh_en = !r_pend_valid || !pair_good;

    always_comb begin
        n_ts_high     = r_ts_high;
        n_pend_valid  = r_pend_valid;
        n_pend_addr   = r_pend_addr;
        n_pend_time   = r_pend_time;
        n_pend_charge = r_pend_charge;
        fres          = '0;
        fres_valid    = 1'b0;
        if (accept) begin
            n_pend_valid = 1'b0;
            if (fresh_en) begin
                unique case (w_type)
                    dwpp_pkg::WT_SKIP_A, dwpp_pkg::WT_SKIP_B: begin
                    end
                    dwpp_pkg::WT_TIME: begin
                        unique case (w_info)
                            dwpp_pkg::INFO_TS_LOAD_A, dwpp_pkg::INFO_TS_LOAD_B,
                            dwpp_pkg::INFO_TS_LOAD_C, dwpp_pkg::INFO_TS_LOAD_D: begin
                                n_ts_high = dwpp_pkg::TS_HIGH_W'(w[51:32]);
                            end
                            dwpp_pkg::INFO_TS_LOAD_SHIFT: begin
                                n_ts_high = dwpp_pkg::TS_HIGH_W'(
                                    {w[51:32], {dwpp_pkg::INFO_W{1'b0}}});
                            end
                            default: begin
                            end
                        endcase
                    end
                    dwpp_pkg::WT_DATA: begin
                        fres.chan_address = w_addr;
                        fres.time_stamp   = w_time;
                        if (r_tape_enable && (w_addr == r_tape_addr)) begin
                            fres.kind         = dwpp_pkg::KIND_PATTERN;
                            fres.pattern_code = (r_tape_pattern > dwpp_pkg::PAT_JUNK) ?
                                                dwpp_pkg::PAT_JUNK : r_tape_pattern;
                            fres.packet_id    = w_val;
                            fres_valid        = 1'b1;
                        end else if (i_in.last_in_buffer) begin
                            fres.kind         = dwpp_pkg::KIND_BAD_EOB;
                            fres.charge_value = w_val;
                            fres_valid        = 1'b1;
                        end else begin
                            n_pend_valid  = 1'b1;
                            n_pend_addr   = w_addr;
                            n_pend_time   = w_time;
                            n_pend_charge = w_val;
                        end
                    end
                endcase
            end
        end
    end

    always_comb begin
        o_push.valid                = accept && (r_pend_valid || fres_valid);
        o_push.entry.two            = r_pend_valid && fres_valid;
        o_push.entry.r0             = r_pend_valid ? pair : fres;
        o_push.entry.r0.last_result = !(r_pend_valid && fres_valid);
        o_push.entry.r1             = fres;
        o_push.entry.r1.last_result = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tape_enable  <= 1'b0;
            r_tape_addr    <= '0;
            r_tape_pattern <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dwpp_pkg::CFG_TAPE_ENABLE:  r_tape_enable  <= i_cfg_data[0];
                dwpp_pkg::CFG_TAPE_ADDR:    r_tape_addr    <= i_cfg_data[dwpp_pkg::ADDR_W-1:0];
                dwpp_pkg::CFG_TAPE_PATTERN: r_tape_pattern <= i_cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ts_high    <= '0;
            r_pend_valid <= 1'b0;
        end else begin
            r_ts_high    <= n_ts_high;
            r_pend_valid <= n_pend_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_addr   <= n_pend_addr;
        r_pend_time   <= n_pend_time;
        r_pend_charge <= n_pend_charge;
    end

endmodule

FILE: hw/rtl/dwpp_queue.sv
`include "digitizer_word_pair_parser_top_macros.svh"

module dwpp_queue #(
    parameter int DEPTH = dwpp_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  dwpp_pkg::t_slot  i_push,
    output logic             o_full,
    output dwpp_pkg::t_slot  o_head,
    input  logic             i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    dwpp_pkg::t_entry   r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr;
    logic [PTR_W-1:0]   n_wr;
    logic [PTR_W-1:0]   r_rd;
    logic [PTR_W-1:0]   n_rd;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               push;
    logic               pop;

    assign push   = i_push.valid;
    assign pop    = i_pop;
    assign o_full = (r_count == CNT_W'(DEPTH));

    assign o_head.valid = (r_count != '0);
    assign o_head.entry = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
        if (push && !pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (pop && !push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push.entry;
        end
    end

    `DWPP_ASSERT_SAME(a_no_push_when_full, push, !o_full)
    `DWPP_ASSERT_SAME(a_no_pop_when_empty, pop, o_head.valid)
    `DWPP_ASSERT_SAME(a_count_in_range, 1'b1, r_count <= CNT_W'(DEPTH))

endmodule

FILE: hw/rtl/dwpp_back.sv
`include "digitizer_word_pair_parser_top_macros.svh"

module dwpp_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  dwpp_pkg::t_slot  i_head,
    output logic             o_pop,
    dwpp_out_if.source       o_out
);

    logic                r_valid;
    logic                n_valid;
    logic                r_half;
    logic                n_half;
    dwpp_pkg::t_result   r_data;
    dwpp_pkg::t_result   sel;
    logic                load;
    logic                last_half;

    assign load      = i_head.valid && (!r_valid || o_out.ready);
    assign sel       = r_half ? i_head.entry.r1 : i_head.entry.r0;
    assign last_half = !i_head.entry.two || r_half;
    assign o_pop     = load && last_half;

    always_comb begin
        n_valid = r_valid && !o_out.ready;
        n_half  = r_half;
        if (load) begin
            n_valid = 1'b1;
            n_half  = !last_half;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_half  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_half  <= n_half;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data <= sel;
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.kind         = r_data.kind;
    assign o_out.chan_address = r_data.chan_address;
    assign o_out.time_stamp   = r_data.time_stamp;
    assign o_out.charge_value = r_data.charge_value;
    assign o_out.cfd_value    = r_data.cfd_value;
    assign o_out.pattern_code = r_data.pattern_code;
    assign o_out.packet_id    = r_data.packet_id;
    assign o_out.last_result  = r_data.last_result;

    `DWPP_ASSERT_SAME(a_half_keeps_entry, r_half, i_head.valid && i_head.entry.two)
    `DWPP_ASSERT_SAME(a_half_has_output, r_half, r_valid)
    `DWPP_ASSERT_SAME(a_first_of_two_marks_half, r_valid && !r_data.last_result, r_half)

endmodule

FILE: hw/rtl/digitizer_word_pair_parser_top.sv
// A result is registered in the result queue when its item is accepted, then in the output
// register that drives the output; a data word that may pair waits in the front for the next word.
// Throughput: one item per cycle while the result queue is not full; an item with two
// results is sent as two in turn, absorbed by the result queue between front and output stage.
// The front accepts items while the result queue has a free entry.
// Reset is synchronous and active low; it clears the configuration registers, the stored
// high timestamp bits, the pending pair and the queue, and needs no clearing pass.
module digitizer_word_pair_parser_top #(
    parameter int QUEUE_DEPTH = dwpp_pkg::QUEUE_DEPTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    dwpp_in_if.sink                          i_in,
    dwpp_out_if.source                       o_out,
    input  logic                             i_cfg_we,
    input  logic [dwpp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [dwpp_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    dwpp_pkg::t_slot  push;
    dwpp_pkg::t_slot  head;
    logic             q_full;
    logic             pop;

    dwpp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_q_full   (q_full),
        .o_push     (push)
    );

    dwpp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (q_full),
        .o_head  (head),
        .i_pop   (pop)
    );

    dwpp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule
